[hw/rtl/bpbg_pkg.sv]
// Shared types and constants for the bimodal/gshare branch predictor.
package bpbg_pkg;

    localparam int TALLY_W = 32;
    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] INDEX_BITS_RST = 4'd14;
    localparam logic [CFG_W-1:0] INDEX_BITS_MIN = 4'd8;

    localparam logic [1:0] CTR_WEAK_NT = 2'd1;
    localparam logic [1:0] CTR_MAX     = 2'd3;
    localparam logic [1:0] CTR_MIN     = 2'd0;

    typedef struct packed {
        logic branch;
        logic nt;
        logic btfnt;
        logic bim;
        logic gsh;
    } t_tally_inc;

    typedef struct packed {
        logic [TALLY_W-1:0] branch;
        logic [TALLY_W-1:0] nt;
        logic [TALLY_W-1:0] btfnt;
        logic [TALLY_W-1:0] bim;
        logic [TALLY_W-1:0] gsh;
    } t_tally;

endpackage

[hw/rtl/bpbg_ctr_mem.sv]
// Synchronous counter table: one write port, one registered read port.
module bpbg_ctr_mem #(
    parameter int IDX_W = 14
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [1:0]       o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [1:0]       i_wr_data
);

    logic [1:0] mem [0:(1<<IDX_W)-1];
    logic [1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/bpbg_tally.sv]
// Saturating branch and miss tallies.
module bpbg_tally (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  bpbg_pkg::t_tally_inc i_inc,
    output bpbg_pkg::t_tally     o_tally
);

    bpbg_pkg::t_tally r_tally;
    bpbg_pkg::t_tally n_tally;

    function automatic logic [bpbg_pkg::TALLY_W-1:0] sat_inc(
        input logic [bpbg_pkg::TALLY_W-1:0] v,
        input logic                         inc
    );
        logic [bpbg_pkg::TALLY_W-1:0] res;
        res = v;
        if (inc && (v != bpbg_pkg::TALLY_MAX)) begin
            res = v + {{(bpbg_pkg::TALLY_W-1){1'b0}}, 1'b1};
        end
        return res;
    endfunction

    always_comb begin
        n_tally.branch = sat_inc(r_tally.branch, i_inc.branch);
        n_tally.nt     = sat_inc(r_tally.nt,     i_inc.nt);
        n_tally.btfnt  = sat_inc(r_tally.btfnt,  i_inc.btfnt);
        n_tally.bim    = sat_inc(r_tally.bim,    i_inc.bim);
        n_tally.gsh    = sat_inc(r_tally.gsh,    i_inc.gsh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else if (i_en) begin
            r_tally <= n_tally;
        end
    end

    assign o_tally = r_tally;

endmodule

[hw/rtl/branch_predictor_bimodal_gshare.sv]
// Top level: bimodal and gshare 2-bit predictor evaluator with miss tallies.
//
// Input stream s_axis: one request per resolved conditional branch, tdata =
// {branch_pc, taken, backward} from bit 0 up. Output stream m_axis: one result
// per request with the three predictions and the five running tallies.
// Config: i_cfg_we/i_cfg_wdata write index_bits (log2 of active table
// entries); write only while idle.
// For each request the accept edge reads both counter memories; the finish edge,
// once the output is free, writes the stepped counters back and loads the result.
// s_axis_tready stays low until the write-back of the request in flight has
// landed in the counter memories, so no new request is taken before it is through.
// After reset both tables are swept to weakly-not-taken, one entry per cycle
// over all 2**IDX_W entries; s_axis_tready stays low until the sweep ends.
// History and tallies clear at once; index_bits resets to 14.
// If m_axis_tready is low, the finished result is held and the next request
// is accepted, but it waits in its write-back step until the output frees up.
module branch_predictor_bimodal_gshare #(
    parameter int MAX_TABLE_ENTRIES = 16384,
    parameter int HISTORY_BITS      = 14
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [39:0]    s_axis_tdata,  // branch_pc[31:0], taken, backward, pad
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [167:0]   m_axis_tdata,  // bimodal_guess, gshare_guess, btfnt_guess,
                                          // branch_total, static_nt_misses,
                                          // btfnt_misses, bimodal_misses,
                                          // gshare_misses, pad
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_TABLE_ENTRIES);

    logic [bpbg_pkg::CFG_W-1:0] r_index_bits;
    logic [HISTORY_BITS-1:0]    r_hist;
    logic                       r_clr;
    logic [IDX_W-1:0]           r_clr_addr;
    logic                       r_busy;
    logic [IDX_W-1:0]           r_bi;
    logic [IDX_W-1:0]           r_gi;
    logic                       r_taken;
    logic                       r_bw;
    logic                       r_out_valid;
    logic                       r_bim_guess;
    logic                       r_gsh_guess;
    logic                       r_bw_guess;

    logic [31:0]             in_pc;
    logic                    in_taken;
    logic                    in_bw;
    logic                    accept;
    logic                    finish;
    logic [bpbg_pkg::CFG_W-1:0] k;
    logic [IDX_W-1:0]        mask;
    logic [IDX_W-1:0]        word;
    logic [IDX_W+HISTORY_BITS-1:0] hist_wide;
    logic [IDX_W-1:0]        bi;
    logic [IDX_W-1:0]        gi;
    logic [1:0]              bc;
    logic [1:0]              gc;
    logic [1:0]              bc_next;
    logic [1:0]              gc_next;
    logic                    mem_we;
    logic [IDX_W-1:0]        bim_waddr;
    logic [IDX_W-1:0]        gsh_waddr;
    logic [1:0]              bim_wdata;
    logic [1:0]              gsh_wdata;
    bpbg_pkg::t_tally_inc    inc;
    bpbg_pkg::t_tally        tally;

    function automatic logic [1:0] step_ctr(input logic [1:0] c, input logic t);
        logic [1:0] res;
        res = c;
        if (t) begin
            if (c != bpbg_pkg::CTR_MAX) res = c + 2'd1;
        end else begin
            if (c != bpbg_pkg::CTR_MIN) res = c - 2'd1;
        end
        return res;
    endfunction

    assign in_pc    = s_axis_tdata[31:0];
    assign in_taken = s_axis_tdata[32];
    assign in_bw    = s_axis_tdata[33];

    assign s_axis_tready = !r_busy && !r_clr;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign finish        = r_busy && (!r_out_valid || m_axis_tready);

    always_comb begin
        k = (r_index_bits < bpbg_pkg::INDEX_BITS_MIN) ? bpbg_pkg::INDEX_BITS_MIN
                                                      : r_index_bits;
        for (int i = 0; i < IDX_W; i++) begin
            mask[i] = (i < int'(k));
        end
    end

    assign word      = in_pc[IDX_W+1:2];
    assign hist_wide = {{IDX_W{1'b0}}, r_hist};
    assign bi        = word & mask;
    assign gi        = (word ^ hist_wide[IDX_W-1:0]) & mask;

    assign bc_next = step_ctr(bc, r_taken);
    assign gc_next = step_ctr(gc, r_taken);

    assign mem_we    = r_clr || finish;
    assign bim_waddr = r_clr ? r_clr_addr : r_bi;
    assign gsh_waddr = r_clr ? r_clr_addr : r_gi;
    assign bim_wdata = r_clr ? bpbg_pkg::CTR_WEAK_NT : bc_next;
    assign gsh_wdata = r_clr ? bpbg_pkg::CTR_WEAK_NT : gc_next;

    bpbg_ctr_mem #(.IDX_W(IDX_W)) u_bim_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (bi),
        .o_rd_data (bc),
        .i_wr_en   (mem_we),
        .i_wr_addr (bim_waddr),
        .i_wr_data (bim_wdata)
    );

    bpbg_ctr_mem #(.IDX_W(IDX_W)) u_gsh_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (gi),
        .o_rd_data (gc),
        .i_wr_en   (mem_we),
        .i_wr_addr (gsh_waddr),
        .i_wr_data (gsh_wdata)
    );

    assign inc.branch = 1'b1;
    assign inc.nt     = r_taken;
    assign inc.btfnt  = r_bw != r_taken;
    assign inc.bim    = bc[1] != r_taken;
    assign inc.gsh    = gc[1] != r_taken;

    bpbg_tally u_tally (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (finish),
        .i_inc   (inc),
        .o_tally (tally)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= bpbg_pkg::INDEX_BITS_RST;
        end else if (i_cfg_we) begin
            r_index_bits <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= 1'b1;
            r_clr_addr  <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_hist      <= '0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + {{(IDX_W-1){1'b0}}, 1'b1};
                if (r_clr_addr == {IDX_W{1'b1}}) begin
                    r_clr <= 1'b0;
                end
            end
            if (accept) begin
                r_busy <= 1'b1;
                r_hist <= {r_hist[HISTORY_BITS-2:0], in_taken};
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bi    <= bi;
            r_gi    <= gi;
            r_taken <= in_taken;
            r_bw    <= in_bw;
        end
        if (finish) begin
            r_bim_guess <= bc[1];
            r_gsh_guess <= gc[1];
            r_bw_guess  <= r_bw;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, tally.gsh, tally.bim, tally.btfnt, tally.nt,
                            tally.branch, r_bw_guess, r_gsh_guess, r_bim_guess};

endmodule
